// ----- design/tls_pkg.sv -----
// ----------------------------------------------------------------------------
// tls_pkg
// Types, codes and constants shared by the traffic light sequencer files.
// ----------------------------------------------------------------------------
package tls_pkg;

  localparam int unsigned TickW   = 16;
  localparam int unsigned SecsW   = 3;
  localparam int unsigned PhaseW  = 2;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgDatW = 16;

  // phase codes
  localparam logic [PhaseW-1:0] PhGreen   = 2'd0;
  localparam logic [PhaseW-1:0] PhYellow  = 2'd1;
  localparam logic [PhaseW-1:0] PhRed     = 2'd2;
  localparam logic [PhaseW-1:0] PhStopped = 2'd3;

  // item kinds on the command field
  localparam logic CmdTick = 1'b0;
  localparam logic CmdByte = 1'b1;

  // received command bytes (ASCII)
  localparam logic [7:0] ByteStart   = 8'h49; // 'I'
  localparam logic [7:0] ByteStop    = 8'h50; // 'P'
  localparam logic [7:0] ByteLonger  = 8'h2B; // '+'
  localparam logic [7:0] ByteShorter = 8'h2D; // '-'

  // register indexes
  localparam logic [CfgIdxW-1:0] RegTicksPerSecond = 8'd0;
  localparam logic [CfgIdxW-1:0] RegYellowSeconds  = 8'd1;

  localparam logic [TickW-1:0] TpsReset       = 16'd15625;
  localparam logic [SecsW-1:0] YellowReset    = 3'd1;
  localparam logic [SecsW-1:0] GreenSecsReset = 3'd2;
  localparam logic [SecsW-1:0] RedSecsReset   = 3'd3;
  localparam logic [SecsW-1:0] MaxSecs        = 3'd4;
  localparam logic [SecsW-1:0] MinSecs        = 3'd1;

  typedef struct packed {
    logic       command;
    logic [7:0] rx_byte;
    logic       button_pressed;
  } in_item_t;

  typedef struct packed {
    logic             green_lamp;
    logic             yellow_lamp;
    logic             red_lamp;
    logic             running;
    logic [SecsW-1:0] green_duration;
    logic [SecsW-1:0] red_duration;
  } out_item_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [CfgDatW-1:0] data;
  } cfg_wr_t;

endpackage

// ----- design/tls_if.sv -----
// ----------------------------------------------------------------------------
// tls_if
// Valid/ready channels of the traffic light sequencer: items in, results
// out, configuration writes.
// ----------------------------------------------------------------------------
interface tls_in_if;
  logic              valid;
  logic              ready;
  tls_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tls_out_if;
  logic               valid;
  logic               ready;
  tls_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tls_cfg_if;
  logic             valid;
  logic             ready;
  tls_pkg::cfg_wr_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- design/traffic_light_sequencer.sv -----
// ----------------------------------------------------------------------------
// traffic_light_sequencer
// Traffic light sequencer stepped by timer ticks and received command bytes.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake        payload
//  item_in   in   valid / ready    command, rx_byte, button_pressed
//  item_out  out  valid / ready    lamps, running, green/red durations
//  cfg_wr    in   valid / ready    index (0 ticks/s, 1 yellow s), data
//
//  One item per clock sustained while results are taken. An accepted item
//  waits in the input register; when the output is free, the state updates
//  and the result register loads, ready for the sink to take.
//  Reset leaves the lights stopped, lamps off, green 2 s, red 3 s.
//  A stalled output holds its result; the input register still takes one
//  more item, then ready drops until the result is taken.
//  cfg_wr is always ready.
// ----------------------------------------------------------------------------
module traffic_light_sequencer (
  input  logic       clk_i,
  input  logic       rst_ni,
  tls_in_if.sink     item_in,
  tls_out_if.source  item_out,
  tls_cfg_if.sink    cfg_wr
);

  logic               in_valid;
  tls_pkg::in_item_t  in_item;
  logic               out_free;
  logic               step;
  tls_pkg::out_item_t result;

  // state advances only when the result register can take the outcome
  assign step = in_valid && out_free;

  tls_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_s    (item_in),
    .take_i  (step),
    .valid_o (in_valid),
    .item_o  (in_item)
  );

  tls_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_s  (cfg_wr),
    .step_i (step),
    .item_i (in_item),
    .res_o  (result)
  );

  tls_out_stage u_out_stage (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (step),
    .item_i (result),
    .free_o (out_free),
    .out_m  (item_out)
  );

  // one lamp lit exactly when running
  a_lamps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_out.valid |-> ($countones({item_out.data.green_lamp,
                                    item_out.data.yellow_lamp,
                                    item_out.data.red_lamp}) ==
                        (item_out.data.running ? 1 : 0)))
    else $error("lamp drive does not match running flag");

  // durations stay within one to four seconds
  a_durations: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_out.valid |-> (item_out.data.green_duration >= tls_pkg::MinSecs &&
                        item_out.data.green_duration <= tls_pkg::MaxSecs &&
                        item_out.data.red_duration >= tls_pkg::MinSecs &&
                        item_out.data.red_duration <= tls_pkg::MaxSecs))
    else $error("duration out of range");

  // a held item with a free output becomes a result next cycle
  a_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid && !item_out.valid) |=> item_out.valid)
    else $error("held item not passed to result register");

  // input never accepts while both registers are full and the output stalls
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid && item_out.valid && !item_out.ready) |-> !item_in.ready)
    else $error("input ready while pipeline is full");

endmodule

// ----- design/tls_in_stage.sv -----
// ----------------------------------------------------------------------------
// tls_in_stage
// Input register: holds one accepted item until the core takes it.
// ----------------------------------------------------------------------------
module tls_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  tls_in_if.sink            in_s,
  input  logic              take_i,
  output logic              valid_o,
  output tls_pkg::in_item_t item_o
);

  logic              valid_q, valid_d;
  tls_pkg::in_item_t item_q;
  logic              accept;

  assign in_s.ready = !valid_q || take_i;
  assign accept     = in_s.valid && in_s.ready;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_s.data;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ----- design/tls_core.sv -----
// ----------------------------------------------------------------------------
// tls_core
// Configuration registers, sequencer state and its one-step update.
// ----------------------------------------------------------------------------
module tls_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  tls_cfg_if.sink            cfg_s,
  input  logic               step_i,
  input  tls_pkg::in_item_t  item_i,
  output tls_pkg::out_item_t res_o
);

  logic [tls_pkg::TickW-1:0]  tps_q;
  logic [tls_pkg::SecsW-1:0]  yellow_q;
  logic [tls_pkg::PhaseW-1:0] phase_q, phase_d;
  logic [tls_pkg::SecsW-1:0]  secs_left_q, secs_left_d;
  logic [tls_pkg::TickW-1:0]  tick_q, tick_d;
  logic [tls_pkg::SecsW-1:0]  green_q, green_d;
  logic [tls_pkg::SecsW-1:0]  red_q, red_d;

  logic [tls_pkg::TickW-1:0]  limit;
  logic [tls_pkg::TickW-1:0]  tick_inc;
  logic [tls_pkg::SecsW-1:0]  yellow_len;
  logic [tls_pkg::SecsW-1:0]  secs_dec;
  logic [tls_pkg::PhaseW-1:0] next_phase;
  logic                       enter;

  assign cfg_s.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q    <= tls_pkg::TpsReset;
      yellow_q <= tls_pkg::YellowReset;
    end else if (cfg_s.valid) begin
      if (cfg_s.data.index == tls_pkg::RegTicksPerSecond) begin
        tps_q <= cfg_s.data.data;
      end else if (cfg_s.data.index == tls_pkg::RegYellowSeconds) begin
        yellow_q <= cfg_s.data.data[tls_pkg::SecsW-1:0];
      end
    end
  end

  assign limit      = (tps_q == '0) ? tls_pkg::TickW'(1) : tps_q;
  assign tick_inc   = tick_q + tls_pkg::TickW'(1);
  assign yellow_len = (yellow_q == '0) ? tls_pkg::MinSecs :
                      (yellow_q > tls_pkg::MaxSecs) ? tls_pkg::MaxSecs : yellow_q;
  assign secs_dec   = (secs_left_q != '0) ? secs_left_q - tls_pkg::SecsW'(1) : '0;

  always_comb begin
    phase_d     = phase_q;
    secs_left_d = secs_left_q;
    tick_d      = tick_q;
    green_d     = green_q;
    red_d       = red_q;
    next_phase  = phase_q;
    enter       = 1'b0;
    if (item_i.command == tls_pkg::CmdByte) begin
      case (item_i.rx_byte)
        tls_pkg::ByteStart: begin
          next_phase = tls_pkg::PhGreen;
          enter      = 1'b1;
        end
        tls_pkg::ByteStop: begin
          next_phase = tls_pkg::PhStopped;
          enter      = 1'b1;
        end
        tls_pkg::ByteLonger: begin
          if (phase_q == tls_pkg::PhStopped) begin
            if (green_q < tls_pkg::MaxSecs) green_d = green_q + tls_pkg::SecsW'(1);
            if (red_q < tls_pkg::MaxSecs)   red_d   = red_q + tls_pkg::SecsW'(1);
          end
        end
        tls_pkg::ByteShorter: begin
          if (phase_q == tls_pkg::PhStopped &&
              green_q > tls_pkg::MinSecs && red_q > tls_pkg::MinSecs) begin
            green_d = green_q - tls_pkg::SecsW'(1);
            red_d   = red_q - tls_pkg::SecsW'(1);
          end
        end
        default: ;
      endcase
    end else if (phase_q != tls_pkg::PhStopped) begin
      if (phase_q == tls_pkg::PhGreen && item_i.button_pressed) begin
        next_phase = tls_pkg::PhYellow;
        enter      = 1'b1;
      end else if (tick_inc < limit) begin
        tick_d = tick_inc;
      end else begin
        // second boundary
        tick_d      = '0;
        secs_left_d = secs_dec;
        if (secs_dec == '0) begin
          enter = 1'b1;
          unique case (phase_q)
            tls_pkg::PhGreen:  next_phase = tls_pkg::PhYellow;
            tls_pkg::PhYellow: next_phase = tls_pkg::PhRed;
            default:           next_phase = tls_pkg::PhGreen;
          endcase
        end
      end
    end
    if (enter) begin
      phase_d = next_phase;
      tick_d  = '0;
      unique case (next_phase)
        tls_pkg::PhGreen:  secs_left_d = green_q;
        tls_pkg::PhYellow: secs_left_d = yellow_len;
        tls_pkg::PhRed:    secs_left_d = red_q;
        default:           secs_left_d = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= tls_pkg::PhStopped;
      secs_left_q <= '0;
      tick_q      <= '0;
      green_q     <= tls_pkg::GreenSecsReset;
      red_q       <= tls_pkg::RedSecsReset;
    end else if (step_i) begin
      phase_q     <= phase_d;
      secs_left_q <= secs_left_d;
      tick_q      <= tick_d;
      green_q     <= green_d;
      red_q       <= red_d;
    end
  end

  assign res_o.green_lamp     = (phase_d == tls_pkg::PhGreen);
  assign res_o.yellow_lamp    = (phase_d == tls_pkg::PhYellow);
  assign res_o.red_lamp       = (phase_d == tls_pkg::PhRed);
  assign res_o.running        = (phase_d != tls_pkg::PhStopped);
  assign res_o.green_duration = green_d;
  assign res_o.red_duration   = red_d;

endmodule

// ----- design/tls_out_stage.sv -----
// ----------------------------------------------------------------------------
// tls_out_stage
// Result register: holds one result until the sink takes it.
// ----------------------------------------------------------------------------
module tls_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  tls_pkg::out_item_t item_i,
  output logic               free_o,
  tls_out_if.source          out_m
);

  logic               valid_q, valid_d;
  tls_pkg::out_item_t item_q;

  assign free_o = !valid_q || out_m.ready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_m.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= item_i;
    end
  end

  assign out_m.valid = valid_q;
  assign out_m.data  = item_q;

endmodule
